>>> sv/texcoord_grid_atlas_packer_defines.svh
// texcoord_grid_atlas_packer_defines.svh: assertion macros for the packer rtl
// no dependencies; the bodies are empty when SYNTH is defined
`ifndef TEXCOORD_GRID_ATLAS_PACKER_DEFINES_SVH
`define TEXCOORD_GRID_ATLAS_PACKER_DEFINES_SVH
`ifndef SYNTH
`define TGAP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);
`define TGAP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TGAP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define TGAP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

>>> sv/tgap_pkg.sv
// tgap_pkg: widths, codes and types shared by the texcoord atlas packer
// no dependencies
`default_nettype none
package tgap_pkg;
  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = COORD_FRAC_BITS + 1;
  localparam int RATIO_FRAC      = 16;
  localparam int RATIO_W         = 24;
  localparam int ROW_RATIO_W     = RATIO_FRAC + 1;
  localparam int NMESH_W         = 13;
  localparam int LEVEL_W         = 5;
  localparam int LEVEL_CAP       = 31;
  localparam int WIDE_W          = 56;
  localparam int DIV_BITS        = COORD_FRAC_BITS + RATIO_FRAC + 1;
  localparam int DIV_CNT_W       = $clog2(DIV_BITS);
  localparam int CFG_DATA_W      = RATIO_W;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [RATIO_W-1:0] ratio_t;
  typedef logic [NMESH_W-1:0] nmesh_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [0:0]         cfg_index_t;

  localparam coord_t     ONE_Q          = COORD_W'(1) << COORD_FRAC_BITS;
  localparam coord_t     COORD_MAX      = '1;
  localparam ratio_t     RATIO_ONE      = RATIO_W'(1) << RATIO_FRAC;
  localparam cfg_index_t CFG_WH_RATIO   = 1'b0;
  localparam cfg_index_t CFG_NUM_MESHES = 1'b1;

  typedef enum logic {MODE_ROWS, MODE_COLS} layout_mode_t;
  typedef enum logic {KIND_COORD, KIND_BATCH} item_kind_t;

  typedef struct packed {
    coord_t     u;
    coord_t     v;
    item_kind_t kind;
    logic       mesh_end;
  } item_t;

  typedef struct packed {
    layout_mode_t mode;
    level_t       level;
    coord_t       slot_step;
  } layout_res_t;

  typedef enum logic [1:0] {LY_IDLE, LY_SEARCH, LY_DIVIDE, LY_DONE} layout_state_t;
  typedef enum logic [1:0] {BK_RUN, BK_SETUP, BK_ISSUE} back_state_t;
endpackage
`default_nettype wire

>>> sv/tgap_front.sv
// tgap_front: input side of the packer, two-entry item queue with classification
// depends on tgap_pkg
`default_nettype none
module tgap_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  tgap_pkg::coord_t in_u_in,
  input  tgap_pkg::coord_t in_v_in,
  input  logic            in_batch_start,
  input  logic            in_mesh_end,
  output logic            head_valid,
  output tgap_pkg::item_t head_item,
  input  logic            head_pop
);
  import tgap_pkg::*;

  item_t      fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;
  item_t      in_item;

  always_comb begin
    in_item.u        = in_u_in;
    in_item.v        = in_v_in;
    in_item.kind     = in_batch_start ? KIND_BATCH : KIND_COORD;
    in_item.mesh_end = in_mesh_end;
  end

  assign in_stall   = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = fifo_r[rd_ptr_r];
  assign push       = in_valid && !in_stall;
  assign pop        = head_pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_item;
    end
  end
endmodule
`default_nettype wire

>>> sv/tgap_layout.sv
// tgap_layout: per-batch layout search (one halving per cycle) and the
// bit-serial divider for the column slot step; depends on tgap_pkg
`default_nettype none
module tgap_layout #(
  parameter int MAX_MESHES = 4096,
  parameter int BPL_W      = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  tgap_pkg::ratio_t      wh_ratio,
  input  tgap_pkg::nmesh_t      num_meshes,
  output logic                  done,
  output tgap_pkg::layout_res_t res,
  output logic [BPL_W-1:0]      bpl
);
  import tgap_pkg::*;

  layout_state_t              state_r, state_nxt;
  layout_mode_t               mode_r, mode_nxt;
  level_t                     level_r, level_nxt;
  logic [BPL_W-1:0]           b_r, b_nxt;
  logic [WIDE_W-1:0]          d_r, d_nxt;
  logic [WIDE_W-1:0]          rem_r, rem_nxt;
  coord_t                     quo_r, quo_nxt;
  coord_t                     step_r, step_nxt;
  logic [DIV_CNT_W-1:0]       idx_r, idx_nxt;

  logic [BPL_W-1:0]           n_clamp;
  logic [ROW_RATIO_W+BPL_W-1:0] row_prod;
  logic                       row_more;
  logic                       col_more;
  logic                       more;
  logic [BPL_W:0]             b_inc;
  coord_t                     row_step;
  logic                       nbit;
  logic [WIDE_W:0]            rem_sh;
  logic                       qbit;

  always_comb begin
    if (num_meshes == '0) begin
      n_clamp = BPL_W'(1);
    end else if (32'(num_meshes) > MAX_MESHES) begin
      n_clamp = BPL_W'(MAX_MESHES);
    end else begin
      n_clamp = BPL_W'(num_meshes);
    end
  end

  // rows: ratio * blocks against 2^(16+k); columns: blocks * 2^16 against ratio * 2^k
  always_comb begin
    row_prod = wh_ratio[ROW_RATIO_W-1:0] * b_r;
    row_more = WIDE_W'(row_prod) > (WIDE_W'(1) << (RATIO_FRAC + int'(level_r)));
    col_more = (WIDE_W'(b_r) << RATIO_FRAC) > (WIDE_W'(wh_ratio) << level_r);
    more     = (level_r != LEVEL_W'(LEVEL_CAP))
            && ((mode_r == MODE_COLS) ? col_more : row_more);
    b_inc    = {1'b0, b_r} + (BPL_W+1)'(1);
    row_step = COORD_W'((WIDE_W'(wh_ratio) << COORD_FRAC_BITS)
                        >> (RATIO_FRAC + int'(level_r)));
    // numerator is a single one bit at the top of the dividend
    nbit     = (idx_r == DIV_CNT_W'(DIV_BITS - 1));
    rem_sh   = {rem_r, nbit};
    qbit     = (rem_sh >= {1'b0, d_r});
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    level_nxt = level_r;
    b_nxt     = b_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      LY_IDLE: begin
        if (start) begin
          mode_nxt  = (wh_ratio > RATIO_ONE) ? MODE_COLS : MODE_ROWS;
          level_nxt = '0;
          b_nxt     = n_clamp;
          state_nxt = LY_SEARCH;
        end
      end
      LY_SEARCH: begin
        if (more) begin
          level_nxt = level_r + LEVEL_W'(1);
          b_nxt     = b_inc[BPL_W:1];
        end else if (mode_r == MODE_ROWS) begin
          step_nxt  = row_step;
          state_nxt = LY_DONE;
        end else begin
          d_nxt     = WIDE_W'(wh_ratio) << level_r;
          rem_nxt   = '0;
          quo_nxt   = '0;
          idx_nxt   = DIV_CNT_W'(DIV_BITS - 1);
          state_nxt = LY_DIVIDE;
        end
      end
      LY_DIVIDE: begin
        if (qbit) begin
          rem_nxt = WIDE_W'(rem_sh - {1'b0, d_r});
        end else begin
          rem_nxt = rem_sh[WIDE_W-1:0];
        end
        quo_nxt = {quo_r[COORD_W-2:0], qbit};
        if (idx_r == '0) begin
          step_nxt  = quo_nxt;
          state_nxt = LY_DONE;
        end else begin
          idx_nxt = idx_r - DIV_CNT_W'(1);
        end
      end
      LY_DONE: begin
        state_nxt = LY_IDLE;
      end
      default: begin
        state_nxt = LY_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LY_IDLE;
      mode_r  <= MODE_ROWS;
      level_r <= '0;
      b_r     <= BPL_W'(1);
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      level_r <= level_nxt;
      b_r     <= b_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    idx_r <= idx_nxt;
  end

  assign done          = (state_r == LY_DONE);
  assign res.mode      = mode_r;
  assign res.level     = level_r;
  assign res.slot_step = step_r;
  assign bpl           = b_r;
endmodule
`default_nettype wire

>>> sv/tgap_back.sv
// tgap_back: back end of the packer, block position state, result forming,
// slot advance and output register; depends on tgap_pkg and the defines header
`default_nettype none
`include "texcoord_grid_atlas_packer_defines.svh"
module tgap_back #(
  parameter int BPL_W = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  tgap_pkg::item_t       head_item,
  output logic                  head_pop,
  output logic                  lay_start,
  input  logic                  lay_done,
  input  tgap_pkg::layout_res_t lay_res,
  input  logic [BPL_W-1:0]      lay_bpl,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tgap_pkg::coord_t      out_u_out,
  output tgap_pkg::coord_t      out_v_out,
  output tgap_pkg::level_t      out_level_used
);
  import tgap_pkg::*;

  back_state_t      state_r, state_nxt;
  layout_mode_t     mode_r, mode_nxt;
  level_t           level_r, level_nxt;
  logic [BPL_W-1:0] bpl_r, bpl_nxt;
  logic [BPL_W-1:0] slot_r, slot_nxt;
  coord_t           off_u_r, off_u_nxt;
  coord_t           off_v_r, off_v_nxt;
  coord_t           step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  coord_t           out_u_r, out_u_nxt;
  coord_t           out_v_r, out_v_nxt;
  level_t           out_level_r, out_level_nxt;

  logic             out_free;
  logic             issue;
  coord_t           shift_u, shift_v;
  logic [COORD_W:0] sum_u, sum_v;
  logic [BPL_W:0]   slot_inc;
  logic             wrap;
  coord_t           line_step;

  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    logic [COORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, COORD_MAX}) ? COORD_MAX : s[COORD_W-1:0];
  endfunction

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    shift_u   = head_item.u >> level_r;
    shift_v   = head_item.v >> level_r;
    sum_u     = {1'b0, shift_u} + {1'b0, off_u_r};
    sum_v     = {1'b0, shift_v} + {1'b0, off_v_r};
    slot_inc  = {1'b0, slot_r} + (BPL_W+1)'(1);
    wrap      = (slot_inc >= {1'b0, bpl_r});
    line_step = (level_r > LEVEL_W'(COORD_FRAC_BITS)) ? '0 : (ONE_Q >> level_r);
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    level_nxt     = level_r;
    bpl_nxt       = bpl_r;
    slot_nxt      = slot_r;
    off_u_nxt     = off_u_r;
    off_v_nxt     = off_v_r;
    step_nxt      = step_r;
    out_u_nxt     = out_u_r;
    out_v_nxt     = out_v_r;
    out_level_nxt = out_level_r;
    issue         = 1'b0;
    lay_start     = 1'b0;
    unique case (state_r)
      BK_RUN: begin
        if (head_valid) begin
          if (head_item.kind == KIND_BATCH) begin
            lay_start = 1'b1;
            state_nxt = BK_SETUP;
          end else if (out_free) begin
            issue = 1'b1;
          end
        end
      end
      BK_SETUP: begin
        if (lay_done) begin
          mode_nxt  = lay_res.mode;
          level_nxt = lay_res.level;
          step_nxt  = lay_res.slot_step;
          bpl_nxt   = lay_bpl;
          slot_nxt  = '0;
          off_u_nxt = '0;
          off_v_nxt = '0;
          state_nxt = BK_ISSUE;
        end
      end
      BK_ISSUE: begin
        if (out_free) begin
          issue     = 1'b1;
          state_nxt = BK_RUN;
        end
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase

    if (issue) begin
      out_u_nxt     = (sum_u > {1'b0, ONE_Q}) ? ONE_Q : sum_u[COORD_W-1:0];
      out_v_nxt     = (sum_v > {1'b0, ONE_Q}) ? ONE_Q : sum_v[COORD_W-1:0];
      out_level_nxt = level_r;
      // mesh end moves to the next slot, or to the next line after a full line
      if (head_item.mesh_end) begin
        if (wrap) begin
          slot_nxt = '0;
          if (mode_r == MODE_ROWS) begin
            off_u_nxt = '0;
            off_v_nxt = sat_add(off_v_r, line_step);
          end else begin
            off_v_nxt = '0;
            off_u_nxt = sat_add(off_u_r, line_step);
          end
        end else begin
          slot_nxt = slot_inc[BPL_W-1:0];
          if (mode_r == MODE_ROWS) begin
            off_u_nxt = sat_add(off_u_r, step_r);
          end else begin
            off_v_nxt = sat_add(off_v_r, step_r);
          end
        end
      end
    end

    if (issue) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign head_pop = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      mode_r      <= MODE_ROWS;
      level_r     <= '0;
      bpl_r       <= BPL_W'(1);
      slot_r      <= '0;
      off_u_r     <= '0;
      off_v_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      level_r     <= level_nxt;
      bpl_r       <= bpl_nxt;
      slot_r      <= slot_nxt;
      off_u_r     <= off_u_nxt;
      off_v_r     <= off_v_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_u_r     <= out_u_nxt;
    out_v_r     <= out_v_nxt;
    out_level_r <= out_level_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_u_out      = out_u_r;
  assign out_v_out      = out_v_r;
  assign out_level_used = out_level_r;

  `TGAP_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_valid_r && out_stall, !issue, "result overwritten while stalled")
  `TGAP_ASSERT_IMP(a_slot_in_range, clk, rst_n, 1'b1, slot_r < bpl_r, "slot index past blocks per line")
  `TGAP_ASSERT_IMP(a_batch_after_setup, clk, rst_n, issue && head_item.kind == KIND_BATCH, state_r == BK_ISSUE, "batch item issued before layout")
  `TGAP_ASSERT_NXT(a_setup_clears_pos, clk, rst_n, state_r == BK_SETUP && lay_done, slot_r == '0 && off_u_r == '0 && off_v_r == '0, "position not cleared on new layout")
endmodule
`default_nettype wire

>>> sv/texcoord_grid_atlas_packer.sv
// a coordinate item passes through the input queue and then the output register
// throughput: one coordinate item per cycle once set up, while out_stall is low
// a batch start item first runs the layout search, halving level by level, and in
// column mode then a bit-serial slot-step divide
// reset (rst_n, synchronous): ratio 1.0, one mesh, scale 1, zero offsets, queue empty
`default_nettype none
module texcoord_grid_atlas_packer #(
  parameter int MAX_MESHES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tgap_pkg::coord_t     in_u_in,
  input  tgap_pkg::coord_t     in_v_in,
  input  logic                 in_batch_start,
  input  logic                 in_mesh_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tgap_pkg::coord_t     out_u_out,
  output tgap_pkg::coord_t     out_v_out,
  output tgap_pkg::level_t     out_level_used,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  tgap_pkg::cfg_index_t cfg_index,
  input  logic [tgap_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tgap_pkg::*;

  localparam int BPL_W = $clog2(MAX_MESHES + 1);

  ratio_t           wh_ratio_r;
  nmesh_t           num_meshes_r;
  logic             head_valid;
  item_t            head_item;
  logic             head_pop;
  logic             lay_start;
  logic             lay_done;
  layout_res_t      lay_res;
  logic [BPL_W-1:0] lay_bpl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wh_ratio_r   <= RATIO_ONE;
      num_meshes_r <= NMESH_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WH_RATIO:   wh_ratio_r   <= cfg_data[RATIO_W-1:0];
        CFG_NUM_MESHES: num_meshes_r <= cfg_data[NMESH_W-1:0];
      endcase
    end
  end

  tgap_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_u_in        (in_u_in),
    .in_v_in        (in_v_in),
    .in_batch_start (in_batch_start),
    .in_mesh_end    (in_mesh_end),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .head_pop       (head_pop)
  );

  tgap_layout #(
    .MAX_MESHES (MAX_MESHES),
    .BPL_W      (BPL_W)
  ) u_layout (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (lay_start),
    .wh_ratio   (wh_ratio_r),
    .num_meshes (num_meshes_r),
    .done       (lay_done),
    .res        (lay_res),
    .bpl        (lay_bpl)
  );

  tgap_back #(
    .BPL_W (BPL_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .head_pop       (head_pop),
    .lay_start      (lay_start),
    .lay_done       (lay_done),
    .lay_res        (lay_res),
    .lay_bpl        (lay_bpl),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_u_out      (out_u_out),
    .out_v_out      (out_v_out),
    .out_level_used (out_level_used)
  );
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking bench for texcoord_grid_atlas_packer, with a built-in grid predictor
// depends on tgap_pkg and the packer rtl; directed table first, then random batches
`default_nettype none
module tb_top;
  import tgap_pkg::*;

  localparam int       MESH_CAP     = 4096;
  localparam int       RANDOM_ITEMS = 850;
  localparam int       QUIET_LIMIT  = 2000;
  localparam int       HOLD_CYCLES  = 300;
  localparam int       SETTLE       = 6;
  localparam coord_t   ONE          = ONE_Q;
  localparam coord_t   CMAX         = COORD_MAX;
  localparam bit [63:0] WIDE_ONE    = 64'd1 << COORD_FRAC_BITS;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    coord_t u;
    coord_t v;
    level_t lvl;
  } texcoord_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_index_t  idx;
    logic [23:0] data;
    coord_t      u;
    coord_t      v;
    logic        bs;
    logic        me;
    logic        typed;
    coord_t      eu;
    coord_t      ev;
    level_t      el;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_u_in = '0;
  coord_t in_v_in = '0;
  logic in_batch_start = 1'b0;
  logic in_mesh_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t out_u_out;
  coord_t out_v_out;
  level_t out_level_used;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_index_t cfg_index = CFG_WH_RATIO;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  texcoord_grid_atlas_packer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_u_in(in_u_in), .in_v_in(in_v_in),
    .in_batch_start(in_batch_start), .in_mesh_end(in_mesh_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_u_out(out_u_out), .out_v_out(out_v_out), .out_level_used(out_level_used),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // predictor state: registers and grid position as the block should hold them
  ratio_t       grid_ratio;
  nmesh_t       grid_meshes;
  layout_mode_t grid_mode;
  int unsigned  grid_level;
  bit [63:0]    grid_blocks, grid_slot, grid_off_u, grid_off_v, grid_step;

  texcoord_t pending_texcoords[$];
  int        errors = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  int        row_layouts = 0;
  int        col_layouts = 0;
  int        deepest_level = 0;
  int        quiet_cycles = 0;

  // typed expectation travels with the item currently driven
  logic      drv_typed = 1'b0;
  texcoord_t drv_expect = '0;

  // receiver pacing
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int run_left = 0;
  bit run_stalled = 1'b0;

  function automatic bit [63:0] clamp_add(bit [63:0] a, bit [63:0] b);
    bit [63:0] s;
    s = a + b;
    return (s > 64'(CMAX)) ? 64'(CMAX) : s;
  endfunction

  task automatic plan_atlas_grid();
    bit [63:0]   n;
    bit [63:0]   r;
    bit [63:0]   b;
    int unsigned k;
    n = 64'(grid_meshes);
    if (n == 0) n = 1;
    if (n > MESH_CAP) n = MESH_CAP;
    b = n;
    r = 64'(grid_ratio);
    k = 0;
    if (r <= 64'd65536) begin
      grid_mode = MODE_ROWS;
      while (k < LEVEL_CAP && r * b > (64'd1 << (16 + k))) begin
        k++;
        b = (b + 1) >> 1;
      end
      grid_step = ((r << COORD_FRAC_BITS) >> (16 + k)) & 64'(CMAX);
      row_layouts++;
    end else begin
      grid_mode = MODE_COLS;
      while (k < LEVEL_CAP && (b << 16) > (r << k)) begin
        k++;
        b = (b + 1) >> 1;
      end
      grid_step = ((WIDE_ONE << 16) / (r << k)) & 64'(CMAX);
      col_layouts++;
    end
    grid_level = k;
    grid_blocks = b;
    grid_slot = 0;
    grid_off_u = 0;
    grid_off_v = 0;
    if (int'(k) > deepest_level) deepest_level = int'(k);
  endtask

  task automatic step_to_next_block();
    bit [63:0] line_step;
    line_step = (grid_level > COORD_FRAC_BITS) ? 64'd0 : (WIDE_ONE >> grid_level);
    grid_slot++;
    if (grid_slot >= grid_blocks) begin
      grid_slot = 0;
      if (grid_mode == MODE_ROWS) begin
        grid_off_u = 0;
        grid_off_v = clamp_add(grid_off_v, line_step);
      end else begin
        grid_off_v = 0;
        grid_off_u = clamp_add(grid_off_u, line_step);
      end
    end else if (grid_mode == MODE_ROWS) begin
      grid_off_u = clamp_add(grid_off_u, grid_step);
    end else begin
      grid_off_v = clamp_add(grid_off_v, grid_step);
    end
  endtask

  function automatic texcoord_t place_texcoord(coord_t u, coord_t v);
    texcoord_t t;
    bit [63:0] su;
    bit [63:0] sv;
    su = (64'(u) >> grid_level) + grid_off_u;
    sv = (64'(v) >> grid_level) + grid_off_v;
    if (su > WIDE_ONE) su = WIDE_ONE;
    if (sv > WIDE_ONE) sv = WIDE_ONE;
    t.u = coord_t'(su);
    t.v = coord_t'(sv);
    t.lvl = level_t'(grid_level);
    return t;
  endfunction

  function automatic void report_field(string name, int exp_val, int act_val);
    errors++;
    $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
  endfunction

  // accepted items feed the predictor, accepted results are checked in order
  always @(posedge clk) begin
    texcoord_t exp_t;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WH_RATIO) grid_ratio = ratio_t'(cfg_data);
        else grid_meshes = nmesh_t'(cfg_data);
      end
      if (in_valid && !in_stall) begin
        if (in_batch_start) plan_atlas_grid();
        exp_t = place_texcoord(in_u_in, in_v_in);
        pending_texcoords.push_back(drv_typed ? drv_expect : exp_t);
        if (in_mesh_end) step_to_next_block();
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_texcoords.size() == 0) begin
          errors++;
          $error("result with no item outstanding: u %0d v %0d level %0d",
                 out_u_out, out_v_out, out_level_used);
        end else begin
          exp_t = pending_texcoords.pop_front();
          if (out_u_out !== exp_t.u) report_field("u_out", exp_t.u, out_u_out);
          if (out_v_out !== exp_t.v) report_field("v_out", exp_t.v, out_v_out);
          if (out_level_used !== exp_t.lvl)
            report_field("level_used", exp_t.lvl, out_level_used);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_texcoords.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic int burst_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_stalled = ($urandom_range(0, 2) == 0);
        run_left = run_stalled ? burst_len() : $urandom_range(1, 8);
      end
      out_stall <= run_stalled;
      run_left--;
    end
  end

  function automatic int sender_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(coord_t u, coord_t v, logic bs, logic me,
                           logic typed, texcoord_t expect_t);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_u_in <= u;
    in_v_in <= v;
    in_batch_start <= bs;
    in_mesh_end <= me;
    drv_typed = typed;
    drv_expect = expect_t;
    do @(posedge clk); while (in_stall);
    items_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // block idle: input lowered, every result back, then a settle wait
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_texcoords.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 12) return ONE;
    if (r < 20) return coord_t'($urandom_range(65537, 131071));
    return coord_t'($urandom_range(0, 65536));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_ratio();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 24'd1;
      2: return 24'd65536;
      3: return 24'd65537;
      4: return 24'hFFFFFF;
      5, 6: return 24'($urandom_range(1, 65536));
      7, 8: return 24'($urandom_range(65537, 24'hFFFFFF));
      default: return 24'($urandom_range(65537, 4 * 65536));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_mesh_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 24'd4096;
      2: return 24'd8191;
      3: return 24'($urandom_range(1, 8191));
      default: return 24'($urandom_range(1, 24));
    endcase
  endfunction

  dir_row_t dir_table [0:31] = '{
    '{ROW_ITEM, CFG_WH_RATIO, 0, 0, 0, 0, 0, 1, 0, 0, 0},        // no batch yet: scale 1
    '{ROW_ITEM, CFG_WH_RATIO, 0, ONE, ONE, 0, 0, 1, ONE, ONE, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, CMAX, CMAX, 0, 0, 1, ONE, ONE, 0}, // above 1.0 saturates
    '{ROW_ITEM, CFG_WH_RATIO, 0, 0, 0, 0, 1, 1, 0, 0, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, 0, 0, 0, 0, 1, 0, ONE, 0},      // next line of the reset grid
    '{ROW_ITEM, CFG_WH_RATIO, 0, 'h8000, 'h4000, 1, 0, 1, 'h8000, 'h4000, 0},
    '{ROW_CFG, CFG_NUM_MESHES, 4, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, ONE, ONE, 1, 1, 1, 'h8000, 'h8000, 1},
    '{ROW_ITEM, CFG_WH_RATIO, 0, ONE, 0, 0, 1, 0, 0, 0, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, 0, ONE, 0, 1, 0, 0, 0, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, 'h1234, 'hFEDC, 0, 1, 0, 0, 0, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, 'h15555, 'h0AAAA, 0, 1, 0, 0, 0, 0}, // past the last mesh
    '{ROW_ITEM, CFG_WH_RATIO, 0, ONE, ONE, 0, 1, 0, 0, 0, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, CMAX, CMAX, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, CFG_WH_RATIO, 0, 0, 0, 0, 0, 0, 0, 0, 0},          // zero ratio
    '{ROW_CFG, CFG_NUM_MESHES, 0, 0, 0, 0, 0, 0, 0, 0, 0},        // zero mesh count
    '{ROW_ITEM, CFG_WH_RATIO, 0, CMAX, CMAX, 1, 1, 1, ONE, ONE, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, 'h0AAAA, 'h15555, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, CFG_WH_RATIO, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, CFG_NUM_MESHES, 8191, 0, 0, 0, 0, 0, 0, 0, 0},     // clamped to the mesh cap
    '{ROW_ITEM, CFG_WH_RATIO, 0, ONE, ONE, 1, 1, 0, 0, 0, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, ONE, ONE, 0, 1, 0, 0, 0, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, 'h7FFF, 'hFFFF, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, CFG_WH_RATIO, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, CFG_NUM_MESHES, 4096, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, 'h15555, 'h0AAAA, 1, 1, 0, 0, 0, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, ONE, ONE, 0, 1, 0, 0, 0, 0},
    '{ROW_CFG, CFG_WH_RATIO, 65537, 0, 0, 0, 0, 0, 0, 0, 0},      // just into column mode
    '{ROW_CFG, CFG_NUM_MESHES, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, ONE, ONE, 1, 1, 0, 0, 0, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CFG_WH_RATIO, 0, 'h0FFFF, 'h10000, 0, 1, 0, 0, 0, 0}
  };

  initial begin
    logic [CFG_DATA_W-1:0] ratio_val;
    logic [CFG_DATA_W-1:0] mesh_val;
    int        eff_meshes;
    int        mesh_total;
    int        coords;
    int        batches;
    int        phase;
    texcoord_t none_t;
    none_t = '0;
    grid_ratio = RATIO_ONE;
    grid_meshes = 1;
    grid_mode = MODE_ROWS;
    grid_level = 0;
    grid_blocks = 1;
    grid_slot = 0;
    grid_off_u = 0;
    grid_off_v = 0;
    grid_step = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        settle_block();
        write_reg(dir_table[i].idx, dir_table[i].data);
      end else begin
        send_item(dir_table[i].u, dir_table[i].v, dir_table[i].bs, dir_table[i].me,
                  dir_table[i].typed,
                  '{u: dir_table[i].eu, v: dir_table[i].ev, lvl: dir_table[i].el});
      end
    end

    phase = 0;
    while (items_sent < RANDOM_ITEMS + 25) begin
      settle_block();
      calm = ($urandom_range(0, 3) == 0);
      ratio_val = rand_ratio();
      mesh_val = rand_mesh_count();
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_WH_RATIO, ratio_val);
        write_reg(CFG_NUM_MESHES, mesh_val);
      end else begin
        write_reg(CFG_NUM_MESHES, mesh_val);
        write_reg(CFG_WH_RATIO, ratio_val);
      end
      eff_meshes = (mesh_val[12:0] == 0) ? 1 :
                   (mesh_val[12:0] > MESH_CAP) ? MESH_CAP : int'(mesh_val[12:0]);
      // receiver goes quiet long enough for the input side to back up
      if (phase == 2 || (phase > 2 && $urandom_range(0, 15) == 0)) begin
        calm = 1'b1;
        hold_request = 1'b1;
      end
      batches = $urandom_range(1, 3);
      repeat (batches) begin
        if (eff_meshes <= 24) begin
          mesh_total = eff_meshes;
          if ($urandom_range(0, 4) == 0) mesh_total += $urandom_range(1, eff_meshes + 3);
        end else begin
          mesh_total = $urandom_range(2, 8);
        end
        for (int m = 0; m < mesh_total; m++) begin
          coords = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
          for (int c = 0; c < coords; c++)
            send_item(rand_coord(), rand_coord(), (m == 0 && c == 0), (c == coords - 1),
                      1'b0, none_t);
        end
      end
      // stray flags: mesh ends and batch starts off the regular pattern
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(3, 10))
          send_item(rand_coord(), rand_coord(), ($urandom_range(0, 7) == 0),
                    1'($urandom_range(0, 1)), 1'b0, none_t);
      end
      phase++;
    end

    settle_block();
    repeat (20) @(posedge clk);
    if (pending_texcoords.size() != 0) begin
      errors++;
      $error("%0d results never arrived", pending_texcoords.size());
    end
    $display("covered %0d items and %0d results over %0d setting phases",
             items_sent, results_seen, phase);
    $display("layouts: %0d in rows, %0d in columns, deepest level %0d, %0d mismatches",
             row_layouts, col_layouts, deepest_level, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
